// ===== hdl/asfi_pkg.sv =====
// Package for the AES forward/inverse byte substitution unit.
// Holds the byte type, field constants and GF(2^8) helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package asfi_pkg;

    typedef logic [7:0] t_byte;

    // Field polynomial x^8+x^4+x^3+x+1, sized for a 15-bit raw product.
    localparam logic [14:0] Poly     = 15'h11B;
    localparam t_byte       FwdConst = 8'h63;
    localparam t_byte       InvConst = 8'h05;

    // Reduces a carry-less product of two bytes modulo the field polynomial.
    function automatic t_byte gf_reduce(input logic [14:0] prod);
        logic [14:0] p;
        p = prod;
        for (int i = 14; i >= 8; i--) begin
            if (p[i]) begin
                p = p ^ (Poly << (i - 8));
            end
        end
        return p[7:0];
    endfunction

    // Squaring is linear over GF(2): spread the bits, then reduce.
    function automatic t_byte gf_sq(input t_byte a);
        logic [14:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            p[2*i] = a[i];
        end
        return gf_reduce(p);
    endfunction

    function automatic t_byte affine_fwd(input t_byte v);
        return v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                 ^ {v[3:0], v[7:4]} ^ FwdConst;
    endfunction

    function automatic t_byte affine_inv(input t_byte v);
        return {v[6:0], v[7]} ^ {v[4:0], v[7:5]} ^ {v[1:0], v[7:2]} ^ InvConst;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/asfi_in_if.sv =====
// Input channel of the substitution unit: valid/ready plus direction and byte.
// Depends on asfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface asfi_in_if
    import asfi_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  kind;
    t_byte data_in;

    modport source (output valid, output kind, output data_in, input ready);
    modport sink   (input valid, input kind, input data_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/asfi_out_if.sv =====
// Output channel of the substitution unit: valid/ready plus the result byte.
// Depends on asfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface asfi_out_if
    import asfi_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/asfi_gf_mul.sv =====
// Combinational GF(2^8) multiplier: carry-less product, then reduction.
// Depends on asfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asfi_gf_mul
    import asfi_pkg::*;
(
    input  wire t_byte i_a,
    input  wire t_byte i_b,
    output t_byte      o_p
);

    logic [14:0] raw;

    always_comb begin
        raw = '0;
        for (int i = 0; i < 8; i++) begin
            if (i_b[i]) begin
                raw = raw ^ ({7'd0, i_a} << i);
            end
        end
        o_p = gf_reduce(raw);
    end

endmodule

`default_nettype wire

// ===== hdl/aes_sbox_forward_inverse_unit.sv =====
// AES byte substitution unit, forward S-box and inverse S-box, selected per
// byte. It accepts one byte every cycle unless an output stall has filled every
// stage. The field inverse is x^254, built from four register stages of one
// GF(2^8) multiply each (x^3, x^15, x^252, x^254); the last stage is the output
// register. A stall on the output backs up stage by stage, so empty stages keep
// filling.
// Depends on asfi_pkg, asfi_in_if, asfi_out_if and asfi_gf_mul.
`timescale 1ns / 1ps
`default_nettype none

module aes_sbox_forward_inverse_unit
    import asfi_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    asfi_in_if.sink     i_in,
    asfi_out_if.source  o_out
);

    logic [3:0] r_vld;
    logic [3:0] en;

    // Stage registers.
    logic  r_kind0, r_kind1, r_kind2;
    t_byte r_v0, r_v1, r_v2;
    t_byte r_x3_0, r_x3_1;
    t_byte r_x15;
    t_byte r_x252;
    t_byte r_data;

    t_byte n_v0, n_x3, n_x15, n_x252, n_x254, n_data;

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        en[3] = !r_vld[3] || o_out.ready;
        en[2] = !r_vld[2] || en[3];
        en[1] = !r_vld[1] || en[2];
        en[0] = !r_vld[0] || en[1];
    end

    assign i_in.ready     = en[0];
    assign o_out.valid    = r_vld[3];
    assign o_out.data_out = r_data;

    assign n_v0 = i_in.kind ? affine_inv(i_in.data_in) : i_in.data_in;

    asfi_gf_mul u_mul0 (.i_a(gf_sq(n_v0)),                .i_b(n_v0),          .o_p(n_x3));
    asfi_gf_mul u_mul1 (.i_a(gf_sq(gf_sq(r_x3_0))),       .i_b(r_x3_0),        .o_p(n_x15));
    asfi_gf_mul u_mul2 (.i_a(gf_sq(gf_sq(gf_sq(gf_sq(r_x15))))),
                        .i_b(gf_sq(gf_sq(r_x3_1))),                            .o_p(n_x252));
    asfi_gf_mul u_mul3 (.i_a(r_x252),                     .i_b(gf_sq(r_v2)),   .o_p(n_x254));

    assign n_data = r_kind2 ? n_x254 : affine_fwd(n_x254);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_in.valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_kind0 <= i_in.kind;
            r_v0    <= n_v0;
            r_x3_0  <= n_x3;
        end
        if (en[1]) begin
            r_kind1 <= r_kind0;
            r_v1    <= r_v0;
            r_x3_1  <= r_x3_0;
            r_x15   <= n_x15;
        end
        if (en[2]) begin
            r_kind2 <= r_kind1;
            r_v2    <= r_v1;
            r_x252  <= n_x252;
        end
        if (en[3]) begin
            r_data  <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/asfi_chk.sv =====
// Port-level checker for the substitution unit, bound to the top level.
// Depends on aes_sbox_forward_inverse_unit and its interface ports.
`timescale 1ns / 1ps
`default_nettype none

module asfi_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_out_data
);

    // With nothing waiting at the output the whole pipeline can move.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output stage is empty");

    // A transfer reaches the output if the output side stays ready while it moves through the stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid)
        else $error("result missing after four cycles of free flow");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped during a stall");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("output data changed during a stall");

endmodule

bind aes_sbox_forward_inverse_unit asfi_chk u_asfi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data_out)
);

`default_nettype wire
